// ===== src/image_difference_statistics_macros.svh =====
// Assertion macros shared by the image difference statistics block.
// Each macro checks a property on the rising edge of clk and is disabled while
// arst_n is low. Define ASSERT_OFF to compile them away.
`ifndef IMAGE_DIFFERENCE_STATISTICS_MACROS_SVH
`define IMAGE_DIFFERENCE_STATISTICS_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define IDS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("image_difference_statistics: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("image_difference_statistics: next-cycle check failed");

`else

`define IDS_ASSERT_NOW(label, ante, cons)
`define IDS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/ids_pkg.sv =====
`timescale 1ns / 1ps

package ids_pkg;

	// Field and accumulator widths.
	localparam int CHAN_W    = 8;
	localparam int COUNT_W   = 25;
	localparam int DSUM_W    = 34;
	localparam int SSUM_W    = 42;
	localparam int RESULT_W  = 16;
	localparam int FRAC_BITS = 8;

	// Pixel counters saturate here.
	localparam logic [COUNT_W-1:0] MAX_PIXELS = COUNT_W'(16777216);

	// Divider and square root sizing.
	localparam int MEAN_BITS = DSUM_W + FRAC_BITS;
	localparam int RMS_BITS  = SSUM_W + 2 * FRAC_BITS;
	localparam int NUM_W     = RMS_BITS;
	localparam int N_W       = COUNT_W + 1;
	localparam int REM_W     = N_W + 1;
	localparam int Q_W       = 2 * RESULT_W;
	localparam int ROOT_W    = RESULT_W;
	localparam int CNT_W     = $clog2(NUM_W + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;

	// One pixel pair.
	typedef struct packed {
		logic [CHAN_W-1:0] first_red;
		logic [CHAN_W-1:0] first_green;
		logic [CHAN_W-1:0] first_blue;
		logic [CHAN_W-1:0] second_red;
		logic [CHAN_W-1:0] second_green;
		logic [CHAN_W-1:0] second_blue;
		logic              last_pixel;
	} pixel_t;

	// One set of frame statistics.
	typedef struct packed {
		logic [CHAN_W-1:0]   max_abs_diff;
		logic [COUNT_W-1:0]  differing_pixels;
		logic [COUNT_W-1:0]  total_pixels;
		logic [RESULT_W-1:0] mean_abs_diff;
		logic [RESULT_W-1:0] root_mean_square;
	} result_t;

endpackage

// ===== src/image_difference_statistics.sv =====
`timescale 1ns / 1ps
// Image difference statistics: compares pixel pairs from two images over the first one to three
// colour channels and, on the pair marked last_pixel, returns the largest channel difference,
// the differing and total pixel counts, and the mean absolute and root mean square differences
// in fixed point with eight fractional bits (truncated); the statistics then start afresh. The
// block takes one pixel request when pixel_stall is low and then compares one channel per cycle
// through a single absolute difference and square unit, so no new pixel is taken until every
// compared channel of the last one is done. The pixel that ends a frame then runs one shared
// subtractor as a restoring divider for the mean (42 steps), the divider again for the mean
// square (58 steps) and a digit-by-digit square root (16 steps), and the next pixel is taken
// only once the result has gone to the output register, later if the previous result has not
// been collected. The finished result waits in an output register, so the next frame may begin
// while it is held. Configuration writes are taken only while the block is idle between pixels.

`include "image_difference_statistics_macros.svh"

module image_difference_statistics (
	input  logic                               clk,
	input  logic                               arst_n,
	// Pixel pair requests.
	input  logic                               pixel_valid,
	output logic                               pixel_stall,
	input  ids_pkg::pixel_t                    pixel,
	// Result requests.
	output logic                               result_valid,
	input  logic                               result_stall,
	output ids_pkg::result_t                   result,
	// Configuration writes.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ids_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ids_pkg::CHAN_W-1:0]         cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHAN,
		S_SETUP,
		S_DIV_MEAN,
		S_DIV_RMS,
		S_SQRT,
		S_EMIT
	} state_t;

	// Configuration registers.
	logic [1:0]                    channels_q;
	logic [ids_pkg::CHAN_W-1:0]    tolerance_q;

	// Control and statistics.
	state_t                        state_q;
	logic [1:0]                    ch_q;
	logic                          differs_q;
	logic [ids_pkg::CHAN_W-1:0]    running_max_q;
	logic [ids_pkg::DSUM_W-1:0]    diff_sum_q;
	logic [ids_pkg::SSUM_W-1:0]    squared_sum_q;
	logic [ids_pkg::COUNT_W-1:0]   differing_count_q;
	logic [ids_pkg::COUNT_W-1:0]   pixel_count_q;
	ids_pkg::pixel_t               pixel_q;

	// Divider and square root.
	logic [ids_pkg::NUM_W-1:0]     num_q;
	logic [ids_pkg::N_W-1:0]       n_q;
	logic [ids_pkg::REM_W-1:0]     rem_q;
	logic [ids_pkg::Q_W-1:0]       quo_q;
	logic                          ovf_q;
	logic [ids_pkg::CNT_W-1:0]     cnt_q;
	logic [ids_pkg::RESULT_W-1:0]  mean_q;
	logic                          rms_ovf_q;
	logic [ids_pkg::ROOT_W-1:0]    root_q;

	// Output register.
	logic                          result_valid_q;
	ids_pkg::result_t              result_q;

	logic [1:0]                    ch_count;
	logic                          last_chan;
	logic [ids_pkg::CHAN_W-1:0]    chan_a;
	logic [ids_pkg::CHAN_W-1:0]    chan_b;
	logic [ids_pkg::CHAN_W-1:0]    abs_diff;
	logic [2*ids_pkg::CHAN_W-1:0]  abs_sq;
	logic                          differs_now;
	logic                          count_open;
	logic [ids_pkg::DSUM_W:0]      dsum_add;
	logic [ids_pkg::SSUM_W:0]      ssum_add;
	logic [ids_pkg::REM_W-1:0]     div_a;
	logic [ids_pkg::REM_W-1:0]     div_b;
	logic [ids_pkg::REM_W-1:0]     sq_a;
	logic [ids_pkg::REM_W-1:0]     sq_b;
	logic [ids_pkg::REM_W-1:0]     alu_a;
	logic [ids_pkg::REM_W-1:0]     alu_b;
	logic [ids_pkg::REM_W:0]       alu_diff;
	logic                          take;
	logic [ids_pkg::REM_W-1:0]     rem_next;
	logic [ids_pkg::Q_W-1:0]       quo_next;
	logic                          ovf_next;
	logic [ids_pkg::RESULT_W-1:0]  mean_value;
	logic                          out_free;
	logic                          emit_now;
	logic                          pixel_accept;

	// Handshake outputs.
	assign pixel_stall  = (state_q != S_IDLE);
	assign pixel_accept = pixel_valid && !pixel_stall;
	assign cfg_ready    = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;
	assign emit_now     = (state_q == S_EMIT) && out_free;

	// Configuration registers; a channel count of zero compares one channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_q  <= 2'd3;
			tolerance_q <= ids_pkg::CHAN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ids_pkg::CFG_CHANNELS:  channels_q  <= cfg_data[1:0];
				ids_pkg::CFG_TOLERANCE: tolerance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ch_count  = (channels_q == 2'd0) ? 2'd1 : channels_q;
	assign last_chan = ((ch_q + 2'd1) == ch_count);

	// Channel selection for the shared difference unit.
	always_comb begin
		case (ch_q)
			2'd0: begin
				chan_a = pixel_q.first_red;
				chan_b = pixel_q.second_red;
			end
			2'd1: begin
				chan_a = pixel_q.first_green;
				chan_b = pixel_q.second_green;
			end
			default: begin
				chan_a = pixel_q.first_blue;
				chan_b = pixel_q.second_blue;
			end
		endcase
	end

	// Absolute difference, its square and the saturating sums.
	assign abs_diff    = (chan_a > chan_b) ? (chan_a - chan_b) : (chan_b - chan_a);
	assign abs_sq      = (2*ids_pkg::CHAN_W)'(abs_diff) * (2*ids_pkg::CHAN_W)'(abs_diff);
	assign differs_now = differs_q || (abs_diff > tolerance_q);
	assign count_open  = (pixel_count_q < ids_pkg::MAX_PIXELS);
	assign dsum_add    = {1'b0, diff_sum_q} + (ids_pkg::DSUM_W+1)'(abs_diff);
	assign ssum_add    = {1'b0, squared_sum_q} + (ids_pkg::SSUM_W+1)'(abs_sq);

	// Operands of the shared subtractor: a division step or a square root step.
	assign div_a = {rem_q[ids_pkg::REM_W-2:0], num_q[ids_pkg::NUM_W-1]};
	assign div_b = ids_pkg::REM_W'(n_q);
	assign sq_a  = ids_pkg::REM_W'({rem_q[ids_pkg::ROOT_W+1:0], quo_q[ids_pkg::Q_W-1 -: 2]});
	assign sq_b  = ids_pkg::REM_W'({root_q, 2'b01});
	assign alu_a = (state_q == S_SQRT) ? sq_a : div_a;
	assign alu_b = (state_q == S_SQRT) ? sq_b : div_b;

	assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
	assign take     = !alu_diff[ids_pkg::REM_W];
	assign rem_next = take ? alu_diff[ids_pkg::REM_W-1:0] : alu_a;

	// Quotient shifts in one bit a step; a bit shifted off the top marks overflow.
	assign quo_next   = {quo_q[ids_pkg::Q_W-2:0], take};
	assign ovf_next   = ovf_q || quo_q[ids_pkg::Q_W-1];
	assign mean_value = (ovf_next || (quo_next[ids_pkg::Q_W-1:ids_pkg::RESULT_W] != '0))
		? '1 : quo_next[ids_pkg::RESULT_W-1:0];

	// Sequencer, statistics and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			ch_q              <= 2'd0;
			differs_q         <= 1'b0;
			running_max_q     <= '0;
			diff_sum_q        <= '0;
			squared_sum_q     <= '0;
			differing_count_q <= '0;
			pixel_count_q     <= '0;
			pixel_q           <= '0;
			num_q             <= '0;
			n_q               <= '0;
			rem_q             <= '0;
			quo_q             <= '0;
			ovf_q             <= 1'b0;
			cnt_q             <= '0;
			mean_q            <= '0;
			rms_ovf_q         <= 1'b0;
			root_q            <= '0;
			result_valid_q    <= 1'b0;
			result_q          <= '0;
		end else begin
			// A new result is shown when handed over; otherwise the held one leaves when taken.
			if (emit_now) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (pixel_accept) begin
						pixel_q   <= pixel;
						ch_q      <= 2'd0;
						differs_q <= 1'b0;
						state_q   <= S_CHAN;
					end
				end

				S_CHAN: begin
					if (abs_diff > running_max_q) begin
						running_max_q <= abs_diff;
					end
					differs_q <= differs_now;
					if (count_open) begin
						diff_sum_q    <= dsum_add[ids_pkg::DSUM_W] ? '1
							: dsum_add[ids_pkg::DSUM_W-1:0];
						squared_sum_q <= ssum_add[ids_pkg::SSUM_W] ? '1
							: ssum_add[ids_pkg::SSUM_W-1:0];
					end
					ch_q <= ch_q + 2'd1;
					if (last_chan) begin
						if (differs_now && (differing_count_q < ids_pkg::MAX_PIXELS)) begin
							differing_count_q <= differing_count_q + ids_pkg::COUNT_W'(1);
						end
						if (count_open) begin
							pixel_count_q <= pixel_count_q + ids_pkg::COUNT_W'(1);
						end
						state_q <= pixel_q.last_pixel ? S_SETUP : S_IDLE;
					end
				end

				// Divisor is the number of channel samples; load the mean division.
				S_SETUP: begin
					n_q     <= ids_pkg::N_W'(pixel_count_q) * ids_pkg::N_W'(ch_count);
					num_q   <= {diff_sum_q, {(ids_pkg::NUM_W-ids_pkg::DSUM_W){1'b0}}};
					rem_q   <= '0;
					quo_q   <= '0;
					ovf_q   <= 1'b0;
					cnt_q   <= ids_pkg::CNT_W'(ids_pkg::MEAN_BITS);
					state_q <= S_DIV_MEAN;
				end

				S_DIV_MEAN: begin
					if (cnt_q == ids_pkg::CNT_W'(1)) begin
						// Mean done; start on the mean square.
						mean_q  <= mean_value;
						num_q   <= {squared_sum_q, {(ids_pkg::NUM_W-ids_pkg::SSUM_W){1'b0}}};
						rem_q   <= '0;
						quo_q   <= '0;
						ovf_q   <= 1'b0;
						cnt_q   <= ids_pkg::CNT_W'(ids_pkg::RMS_BITS);
						state_q <= S_DIV_RMS;
					end else begin
						num_q <= num_q << 1;
						rem_q <= rem_next;
						quo_q <= quo_next;
						ovf_q <= ovf_next;
						cnt_q <= cnt_q - ids_pkg::CNT_W'(1);
					end
				end

				S_DIV_RMS: begin
					num_q <= num_q << 1;
					quo_q <= quo_next;
					if (cnt_q == ids_pkg::CNT_W'(1)) begin
						// The quotient stays in place as the square root operand.
						rms_ovf_q <= ovf_next;
						rem_q     <= '0;
						root_q    <= '0;
						cnt_q     <= ids_pkg::CNT_W'(ids_pkg::ROOT_W);
						state_q   <= S_SQRT;
					end else begin
						rem_q <= rem_next;
						ovf_q <= ovf_next;
						cnt_q <= cnt_q - ids_pkg::CNT_W'(1);
					end
				end

				// One root bit a step from two operand bits.
				S_SQRT: begin
					rem_q  <= rem_next;
					root_q <= {root_q[ids_pkg::ROOT_W-2:0], take};
					quo_q  <= quo_q << 2;
					cnt_q  <= cnt_q - ids_pkg::CNT_W'(1);
					if (cnt_q == ids_pkg::CNT_W'(1)) begin
						state_q <= S_EMIT;
					end
				end

				// Hand over the result once the output register is free and clear the frame.
				S_EMIT: begin
					if (out_free) begin
						result_q.max_abs_diff     <= running_max_q;
						result_q.differing_pixels <= differing_count_q;
						result_q.total_pixels     <= pixel_count_q;
						result_q.mean_abs_diff    <= mean_q;
						result_q.root_mean_square <= rms_ovf_q ? '1 : root_q;
						running_max_q             <= '0;
						diff_sum_q                <= '0;
						squared_sum_q             <= '0;
						differing_count_q         <= '0;
						pixel_count_q             <= '0;
						state_q                   <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// An accepted pixel always starts on its first channel.
	`IDS_ASSERT_NEXT(a_accept_starts, pixel_accept, (state_q == S_CHAN) && (ch_q == 2'd0))

	// The pixel counter never passes its saturation value.
	`IDS_ASSERT_NOW(a_count_cap, 1'b1, pixel_count_q <= ids_pkg::MAX_PIXELS)

	// Differing pixels are a subset of the pixels counted.
	`IDS_ASSERT_NOW(a_differ_bound, 1'b1, differing_count_q <= pixel_count_q)

	// Handing over a result shows it and leaves the statistics cleared.
	`IDS_ASSERT_NEXT(a_emit_clears, emit_now, result_valid_q && (pixel_count_q == '0))

endmodule
